// ----- hdl/gha_pkg.sv -----
// Shared types, sizes and operation codes of the generational handle allocator.
package gha_pkg;

  localparam int SLOT_COUNT   = 1024;
  localparam int VERSION_BITS = 16;
  localparam int IDX_W        = $clog2(SLOT_COUNT);
  localparam int CNT_W        = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CHECK = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  // One slot table entry: live mark and current version.
  typedef struct packed {
    logic                    live;
    logic [VERSION_BITS-1:0] ver;
  } slot_t;

endpackage

// ----- hdl/generational_handle_allocator.sv -----
// Top level: versioned handle allocator over a slot table and a LIFO free stack.
//
//   channel   signals                                        flow control
//   command   start, func, handle_index, handle_version      start while busy low
//   result    done, status, out_index, out_version,          one-cycle strobe,
//             is_live, live_count                            no back pressure
//
// Allocate with a non-empty free stack runs a stack read, then a slot table read
// at the popped index, then the write-back, before the next accept. All other
// operations run one slot table read, then the write-back. The result strobe shows
// in the cycle the block can take the next command. Synchronous reset clears the
// counters and control; the slot table needs no clearing pass, since entries at or
// above the used-slot count are never trusted and a fresh slot is written as it is
// handed out.
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              func,
  input  logic [IDX_W-1:0]        handle_index,
  input  logic [VERSION_BITS-1:0] handle_version,
  output logic                    done,
  output logic [1:0]              status,
  output logic [IDX_W-1:0]        out_index,
  output logic [VERSION_BITS-1:0] out_version,
  output logic                    is_live,
  output logic [CNT_W-1:0]        live_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EVAL
  } state_t;

  state_t                  state;
  func_t                   q_func;
  logic [IDX_W-1:0]        q_idx;
  logic [VERSION_BITS-1:0] q_ver;
  logic                    q_pop;
  logic [CNT_W-1:0]        used_slots;
  logic [CNT_W-1:0]        free_depth;

  // Memories
  slot_t            slot_mem [SLOT_COUNT];
  logic [IDX_W-1:0] stack_mem [SLOT_COUNT];
  slot_t            slot_rdata;
  logic [IDX_W-1:0] stack_rdata;

  logic             accept;
  logic             slot_ren;
  logic [IDX_W-1:0] slot_raddr;
  logic             stack_ren;
  logic [IDX_W-1:0] stack_raddr;

  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr;
  slot_t            slot_wdata;
  logic             stack_we;

  status_t                 res_status;
  logic [IDX_W-1:0]        res_idx;
  logic [VERSION_BITS-1:0] res_ver;
  logic                    res_live;
  logic [CNT_W-1:0]        used_slots_next;
  logic [CNT_W-1:0]        free_depth_next;
  logic                    handle_ok;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // Issue reads: pop address on allocate with stacked slots, else the handle's slot
  always_comb begin
    stack_ren   = accept && (func_t'(func) == FUNC_ALLOC) && (free_depth != '0);
    stack_raddr = IDX_W'(free_depth - CNT_W'(1));
    slot_ren    = (accept && !stack_ren) || (state == S_POP);
    slot_raddr  = (state == S_POP) ? stack_rdata : handle_index;
  end

  always_ff @(posedge clk) begin
    if (stack_ren) begin
      stack_rdata <= stack_mem[stack_raddr];
    end
    if (stack_we) begin
      stack_mem[free_depth[IDX_W-1:0]] <= q_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_ren) begin
      slot_rdata <= slot_mem[slot_raddr];
    end
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  // Evaluate the transaction against the entry read back
  always_comb begin
    res_status      = ST_OK;
    res_idx         = '0;
    res_ver         = '0;
    res_live        = 1'b0;
    used_slots_next = used_slots;
    free_depth_next = free_depth;
    slot_we         = 1'b0;
    slot_waddr      = q_idx;
    slot_wdata      = slot_rdata;
    stack_we        = 1'b0;
    handle_ok       = (CNT_W'(q_idx) < used_slots) && slot_rdata.live &&
                      (slot_rdata.ver == q_ver);
    case (q_func)
      FUNC_ALLOC: begin
        if (q_pop) begin
          // reuse the most recently freed slot
          free_depth_next = free_depth - CNT_W'(1);
          res_idx         = stack_rdata;
          res_ver         = slot_rdata.ver;
          slot_we         = 1'b1;
          slot_waddr      = stack_rdata;
          slot_wdata.live = 1'b1;
          slot_wdata.ver  = slot_rdata.ver;
        end else if (used_slots < CNT_W'(SLOT_COUNT)) begin
          // take a never-used slot; its version starts at zero
          used_slots_next = used_slots + CNT_W'(1);
          res_idx         = used_slots[IDX_W-1:0];
          slot_we         = 1'b1;
          slot_waddr      = used_slots[IDX_W-1:0];
          slot_wdata.live = 1'b1;
          slot_wdata.ver  = '0;
        end else begin
          res_status = ST_FULL;
        end
      end
      FUNC_FREE: begin
        if (handle_ok && (free_depth < CNT_W'(SLOT_COUNT))) begin
          free_depth_next = free_depth + CNT_W'(1);
          slot_we         = 1'b1;
          slot_wdata.live = 1'b0;
          slot_wdata.ver  = slot_rdata.ver + VERSION_BITS'(1);
          stack_we        = 1'b1;
        end else begin
          res_status = ST_STALE;
        end
      end
      FUNC_CHECK: begin
        res_live = handle_ok;
      end
      default: begin
        res_status = ST_STALE;
      end
    endcase
    if (state != S_EVAL) begin
      slot_we  = 1'b0;
      stack_we = 1'b0;
    end
  end

  // Sequence the transaction and hold the result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_slots <= '0;
      free_depth <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            q_func <= func_t'(func);
            q_idx  <= handle_index;
            q_ver  <= handle_version;
            q_pop  <= stack_ren;
            state  <= stack_ren ? S_POP : S_EVAL;
          end
        end
        S_POP: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          used_slots  <= used_slots_next;
          free_depth  <= free_depth_next;
          done        <= 1'b1;
          status      <= res_status;
          out_index   <= res_idx;
          out_version <= res_ver;
          is_live     <= res_live;
          live_count  <= used_slots_next - free_depth_next;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/gha_checker.sv -----
// Port-level checker for the handle allocator, bound to the top level.
module gha_checker
  import gha_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [1:0]              status,
  input logic [IDX_W-1:0]        out_index,
  input logic [VERSION_BITS-1:0] out_version,
  input logic                    is_live,
  input logic [CNT_W-1:0]        live_count
);

  // An accepted transaction occupies the block next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result arrives only as the block finishes work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe without preceding work");

  // Failed transactions carry no handle
  a_fail_no_handle: assert property (@(posedge clk) disable iff (rst)
    done && (status != ST_OK) |-> (out_index == '0) && (out_version == '0))
    else $error("handle fields set on a failed transaction");

  // A live answer only comes with ok status
  a_live_ok: assert property (@(posedge clk) disable iff (rst)
    done && is_live |-> (status == ST_OK))
    else $error("live handle reported with error status");

  // Table full means every slot is live
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> (live_count == CNT_W'(SLOT_COUNT)))
    else $error("table full reported with free slots");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .out_index   (out_index),
  .out_version (out_version),
  .is_live     (is_live),
  .live_count  (live_count)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the generational handle allocator.
import gha_pkg::*;

// Expected result of one command
typedef struct {
  status_t                 status;
  logic [IDX_W-1:0]        index;
  logic [VERSION_BITS-1:0] version;
  logic                    live;
  logic [CNT_W-1:0]        count;
} handle_result_t;

// Slot table mirror plus the queue of results still owed by the block
class handle_ledger;
  logic [VERSION_BITS-1:0] slot_ver [SLOT_COUNT];
  bit                      slot_live [SLOT_COUNT];
  logic [IDX_W-1:0]        free_stack [SLOT_COUNT];
  int                      free_depth;
  int                      used_slots;
  handle_result_t          owed_results[$];
  int failures;
  int n_alloc, n_free, n_check, n_unused, n_full, n_stale, n_hits, n_results;

  function new();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_ver[i]   = '0;
      slot_live[i]  = 1'b0;
      free_stack[i] = '0;
    end
    free_depth = 0;
    used_slots = 0;
    failures = 0;
    n_alloc = 0; n_free = 0; n_check = 0; n_unused = 0;
    n_full = 0; n_stale = 0; n_hits = 0; n_results = 0;
  endfunction

  function bit handle_is_live(logic [IDX_W-1:0] idx, logic [VERSION_BITS-1:0] ver);
    return (int'(idx) < used_slots) && (slot_ver[idx] == ver) && slot_live[idx];
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // Predict the result of an accepted command and update the mirror
  function void note_command(logic [1:0] f, logic [IDX_W-1:0] idx,
                             logic [VERSION_BITS-1:0] ver);
    handle_result_t exp;
    int slot;
    exp.status  = ST_OK;
    exp.index   = '0;
    exp.version = '0;
    exp.live    = 1'b0;
    case (f)
      FUNC_ALLOC: begin
        n_alloc++;
        slot = -1;
        if (free_depth > 0) begin
          free_depth--;
          slot = int'(free_stack[free_depth]);
        end else if (used_slots < SLOT_COUNT) begin
          slot = used_slots;
          used_slots++;
        end
        if (slot < 0) begin
          exp.status = ST_FULL;
          n_full++;
        end else begin
          slot_live[slot] = 1'b1;
          exp.index   = slot[IDX_W-1:0];
          exp.version = slot_ver[slot];
        end
      end
      FUNC_FREE: begin
        n_free++;
        if (handle_is_live(idx, ver) && free_depth < SLOT_COUNT) begin
          slot_live[idx] = 1'b0;
          slot_ver[idx]  = slot_ver[idx] + 1'b1;
          free_stack[free_depth] = idx;
          free_depth++;
        end else begin
          exp.status = ST_STALE;
          n_stale++;
        end
      end
      FUNC_CHECK: begin
        n_check++;
        exp.live = handle_is_live(idx, ver);
        if (exp.live) n_hits++;
      end
      default: begin
        n_unused++;
        exp.status = ST_STALE;
      end
    endcase
    exp.count = CNT_W'(used_slots - free_depth);
    owed_results = {owed_results, exp};
  endfunction

  // Compare one result strobe against the oldest prediction
  function void check_result(logic [1:0] st, logic [IDX_W-1:0] idx,
                             logic [VERSION_BITS-1:0] ver, logic live,
                             logic [CNT_W-1:0] cnt);
    handle_result_t exp;
    if (owed_results.size() == 0) begin
      $error("result with no transaction outstanding (status %0d)", st);
      failures++;
      return;
    end
    exp = owed_results.pop_front();
    n_results++;
    if (st !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, st);
      failures++;
    end
    if (idx !== exp.index) begin
      $error("out_index: expected %0d, got %0d", exp.index, idx);
      failures++;
    end
    if (ver !== exp.version) begin
      $error("out_version: expected %0d, got %0d", exp.version, ver);
      failures++;
    end
    if (live !== exp.live) begin
      $error("is_live: expected %0d, got %0d", exp.live, live);
      failures++;
    end
    if (cnt !== exp.count) begin
      $error("live_count: expected %0d, got %0d", exp.count, cnt);
      failures++;
    end
  endfunction

  // Find a live handle by sampling slots already handed out
  function bit pick_live(output logic [IDX_W-1:0] idx,
                         output logic [VERSION_BITS-1:0] ver);
    int k;
    idx = '0;
    ver = '0;
    if (used_slots == 0) return 1'b0;
    for (int t = 0; t < 16; t++) begin
      k = int'($urandom_range(used_slots - 1));
      if (slot_live[k]) begin
        idx = k[IDX_W-1:0];
        ver = slot_ver[k];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              func;
  logic [IDX_W-1:0]        handle_index;
  logic [VERSION_BITS-1:0] handle_version;
  logic                    done;
  logic [1:0]              status;
  logic [IDX_W-1:0]        out_index;
  logic [VERSION_BITS-1:0] out_version;
  logic                    is_live;
  logic [CNT_W-1:0]        live_count;

  handle_ledger ledger = new();

  generational_handle_allocator DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .handle_index   (handle_index),
    .handle_version (handle_version),
    .done           (done),
    .status         (status),
    .out_index      (out_index),
    .out_version    (out_version),
    .is_live        (is_live),
    .live_count     (live_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check results before noting a transaction taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1)
        ledger.check_result(status, out_index, out_version, is_live, live_count);
      if (start && busy === 1'b0)
        ledger.note_command(func, handle_index, handle_version);
    end
  end

  // Present one command at a falling edge and hold it until it is taken
  task automatic send_command(logic [1:0] f, logic [IDX_W-1:0] idx,
                              logic [VERSION_BITS-1:0] ver);
    start          <= 1'b1;
    func           <= f;
    handle_index   <= idx;
    handle_version <= ver;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop start for a random stretch, weighted by the idle percentage
  task automatic pause_sender(int pct);
    if (pct != 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Hold off until every outstanding transaction has reported
  task automatic drain_results();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (ledger.pending() != 0 && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  task automatic random_transaction();
    logic [IDX_W-1:0]        idx;
    logic [VERSION_BITS-1:0] ver;
    int                      pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_command(FUNC_ALLOC, IDX_W'($urandom), VERSION_BITS'($urandom));
    end else if (pick < 72) begin
      // Free or check a live handle; allocate if none is found
      if (ledger.pick_live(idx, ver))
        send_command((pick < 60) ? FUNC_FREE : FUNC_CHECK, idx, ver);
      else
        send_command(FUNC_ALLOC, IDX_W'($urandom), VERSION_BITS'($urandom));
    end else if (pick < 80) begin
      // Stale version of a slot in use or freed
      if (ledger.used_slots != 0) begin
        idx = IDX_W'($urandom_range(ledger.used_slots - 1));
        ver = ledger.slot_ver[idx] + VERSION_BITS'($urandom_range(1, 3));
      end else begin
        idx = IDX_W'($urandom);
        ver = VERSION_BITS'($urandom);
      end
      send_command($urandom_range(1) ? FUNC_FREE : FUNC_CHECK, idx, ver);
    end else if (pick < 95) begin
      send_command(2'($urandom_range(1, 2)), IDX_W'($urandom), VERSION_BITS'($urandom));
    end else begin
      send_command(FUNC_UNUSED, IDX_W'($urandom), VERSION_BITS'($urandom));
    end
  endtask

  initial begin
    int idle_pct [4];

    idle_pct[0] = 0;
    idle_pct[1] = 70;
    idle_pct[2] = 0;
    idle_pct[3] = 20;
    rst            = 1'b1;
    start          = 1'b0;
    func           = FUNC_ALLOC;
    handle_index   = '0;
    handle_version = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, double free, reuse from the free stack,
    // extreme indexes and versions, unused operation code
    send_command(FUNC_CHECK, 10'd0, 16'd0);
    send_command(FUNC_FREE, 10'd0, 16'd0);
    send_command(FUNC_ALLOC, 10'd0, 16'd0);
    send_command(FUNC_ALLOC, 10'h3FF, 16'hFFFF);
    send_command(FUNC_CHECK, 10'd1, 16'd0);
    send_command(FUNC_CHECK, 10'd1, 16'd1);
    send_command(FUNC_FREE, 10'd1, 16'd0);
    send_command(FUNC_FREE, 10'd1, 16'd0);
    send_command(FUNC_CHECK, 10'd1, 16'd0);
    send_command(FUNC_ALLOC, 10'd0, 16'd0);
    send_command(FUNC_CHECK, 10'd1, 16'd1);
    send_command(FUNC_FREE, 10'd0, 16'hFFFF);
    send_command(FUNC_UNUSED, 10'h3FF, 16'hFFFF);
    send_command(FUNC_CHECK, 10'h3FF, 16'hFFFF);
    send_command(FUNC_CHECK, 10'd2, 16'd0);
    send_command(FUNC_FREE, 10'd1, 16'd1);
    send_command(FUNC_FREE, 10'd0, 16'd0);
    send_command(FUNC_ALLOC, 10'd0, 16'd0);
    send_command(FUNC_ALLOC, 10'd0, 16'd0);
    send_command(FUNC_ALLOC, 10'd0, 16'd0);
    send_command(FUNC_CHECK, 10'd2, 16'd0);
    drain_results();
    @(negedge clk);

    // Random mix in four idle phases, draining between them
    foreach (idle_pct[p]) begin
      repeat (100) begin
        random_transaction();
        pause_sender(idle_pct[p]);
      end
      drain_results();
      @(negedge clk);
    end

    // Wait out the last results and the block's latency
    drain_results();
    repeat (4) @(negedge clk);
    if (ledger.pending() != 0) begin
      $error("%0d transactions never reported a result", ledger.pending());
      ledger.failures++;
    end

    $display("covered %0d results: %0d allocates, %0d frees, %0d checks, %0d unused codes",
             ledger.n_results, ledger.n_alloc, ledger.n_free, ledger.n_check,
             ledger.n_unused);
    $display("  with %0d table-full, %0d stale handles, %0d live checks, four idle phases",
             ledger.n_full, ledger.n_stale, ledger.n_hits);
    if (ledger.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
